FILE: hw/rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Shared micro-operation codes, status codes, the controller/datapath status
// struct and the constant helper that lays out the per-order bitmaps.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_BAD_SZ  = 2'd2;

  // Micro-operations issued by the controller to the datapath.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR,
    OP_LOAD,
    OP_SET_ST1,
    OP_SET_ST2,
    OP_SRCH_INIT,
    OP_SRCH_READ,
    OP_SRCH_NEXT_I,
    OP_SRCH_NEXT_K,
    OP_TAKE,
    OP_ALLOC_GB,
    OP_J_INC,
    OP_FREE_INIT,
    OP_FREE_GB,
    OP_TOP_INIT,
    OP_TOP_GB,
    OP_TOP_SKIP,
    OP_GB_IDX,
    OP_GB_RD_BUDDY,
    OP_GB_SET,
    OP_GB_MERGE
  } op_t;

  // Status flags reported by the datapath.
  typedef struct packed {
    logic is_free;
    logic need_zero;
    logic need_over_total;
    logic so_over;
    logic in_order;
    logic k_top;
    logic rbit;
    logic need_gt_blk;
    logic j_lt_k;
    logic spare_bit;
    logic j_lt_max;
    logic left_bit;
    logic m_lt_left;
    logic top_in_range;
    logic gb_bad;
    logic gb_buddy;
    logic clr_last;
  } flags_t;

  // First bitmap entry of order k: the sum of the block counts below it.
  function automatic int base_of(input int total, input int k);
    int s;
    s = 0;
    for (int j = 0; j < k; j++) begin
      s = s + (total >> j);
    end
    return s;
  endfunction

endpackage

FILE: hw/rtl/bpa_datapath.sv
// ----------------------------------------------------------------------------
// Buddy page allocator datapath
// Holds the free-block bitmap memory, the request registers, the loop
// counters and the result registers, and executes one micro-operation a cycle.
// ----------------------------------------------------------------------------
module bpa_datapath #(
  parameter int PAGE_BYTES  = 4096,
  parameter int MAX_ORDER   = 8,
  parameter int TOTAL_PAGES = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  bpa_pkg::op_t    op,
  output bpa_pkg::flags_t flags,
  input  logic            cfg_we,
  input  logic [31:0]     cfg_wdata,
  input  logic            in_command,
  input  logic [22:0]     in_size_bytes,
  input  logic [3:0]      in_start_order,
  input  logic [31:0]     in_free_address,
  output logic [31:0]     out_block_address,
  output logic [1:0]      out_status
);

  localparam int SHIFT     = $clog2(PAGE_BYTES);
  localparam int NEED_W    = 24 - SHIFT;
  localparam int PN_W      = 33 - SHIFT;
  localparam int KW        = (MAX_ORDER < 2) ? 1 : $clog2(MAX_ORDER + 1);
  localparam int KD        = 1 << KW;
  localparam int IW        = $clog2(TOTAL_PAGES + 1);
  localparam int LW        = $clog2(TOTAL_PAGES + 1);
  localparam int MEM_DEPTH = bpa_pkg::base_of(TOTAL_PAGES, MAX_ORDER + 1);
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int TOP_BASE  = bpa_pkg::base_of(TOTAL_PAGES, MAX_ORDER);

  // Constant table of bitmap base addresses per order.
  logic [AW-1:0] base_tab [KD];
  for (genvar g = 0; g < KD; g++) begin : g_base
    assign base_tab[g] = (g <= MAX_ORDER) ? AW'(bpa_pkg::base_of(TOTAL_PAGES, g)) : '0;
  end

  logic [31:0]        region_base_r;
  logic               cmd_r;
  logic [NEED_W-1:0]  need_r;
  logic [3:0]         so_r;
  logic [PN_W-1:0]    first_r;
  logic [KW-1:0]      k_r, j_r, gk_r;
  logic [IW-1:0]      i_r, gi_r;
  logic [PN_W-1:0]    next_r, m_r, gpn_r;
  logic [MAX_ORDER:0] spare_r;
  logic [LW-1:0]      left_r;
  logic [AW-1:0]      clr_r;
  logic [31:0]        addr_r;
  logic [1:0]         status_r;
  logic               rdata_r;
  logic               mem [MEM_DEPTH];

  logic [NEED_W-1:0]  need_c;
  logic [23:0]        size_sum;
  logic [31:0]        offs;
  logic [31:0]        blk_pages;
  logic [IW-1:0]      n_k, n_gk1;
  logic [PN_W:0]      gb_end;
  logic [PN_W-1:0]    gb_mask;
  logic [PN_W-1:0]    pn_c;
  logic [LW-1:0]      left_dec;
  logic [LW-1:0]      left_sh;
  logic [MAX_ORDER:0] spare_sh;
  logic               mem_we, mem_re, mem_wbit;
  logic [AW-1:0]      mem_addr;

  // Page rounding of the request size and the region offset of a free.
  assign size_sum  = {1'b0, in_size_bytes} + 24'(PAGE_BYTES - 1);
  assign need_c    = NEED_W'(size_sum >> SHIFT);
  assign offs      = in_free_address - region_base_r;
  assign blk_pages = 32'd1 << k_r;
  assign n_k       = IW'(TOTAL_PAGES >> k_r);
  assign n_gk1     = IW'(TOTAL_PAGES >> (gk_r + KW'(1)));
  assign gb_mask   = (PN_W'(1) << gk_r) - PN_W'(1);
  assign gb_end    = {1'b0, gpn_r} + ((PN_W + 1)'(1) << gk_r);
  assign pn_c      = PN_W'(i_r) << k_r;
  assign left_dec  = left_r - (LW'(1) << j_r);
  assign left_sh   = left_r >> j_r;
  assign spare_sh  = spare_r >> j_r;

  // Status flags for the controller.
  always_comb begin
    flags.is_free         = cmd_r;
    flags.need_zero       = (need_r == '0);
    flags.need_over_total = (32'(need_r) > 32'(TOTAL_PAGES));
    flags.so_over         = ({1'b0, so_r} > 5'(MAX_ORDER));
    flags.in_order        = (i_r < n_k);
    flags.k_top           = (k_r == KW'(MAX_ORDER));
    flags.rbit            = rdata_r;
    flags.need_gt_blk     = (32'(need_r) > blk_pages);
    flags.j_lt_k          = (j_r < k_r);
    flags.spare_bit       = spare_sh[0];
    flags.j_lt_max        = (j_r < KW'(MAX_ORDER));
    flags.left_bit        = left_sh[0];
    flags.m_lt_left       = (m_r < PN_W'(left_r));
    flags.top_in_range    = ((first_r + m_r) < PN_W'(TOTAL_PAGES));
    flags.gb_bad          = ((gpn_r & gb_mask) != '0) || (gb_end > (PN_W + 1)'(TOTAL_PAGES));
    flags.gb_buddy        = (gk_r < KW'(MAX_ORDER)) && ((gi_r >> 1) < n_gk1);
    flags.clr_last        = (clr_r == AW'(MEM_DEPTH - 1));
  end

  // Bitmap port control per micro-operation.
  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_wbit = 1'b0;
    mem_addr = base_tab[k_r] + AW'(i_r);
    case (op)
      bpa_pkg::OP_CLR: begin
        mem_we   = 1'b1;
        mem_addr = clr_r;
        mem_wbit = (clr_r >= AW'(TOP_BASE));
      end
      bpa_pkg::OP_SRCH_READ: mem_re = 1'b1;
      bpa_pkg::OP_TAKE:      mem_we = 1'b1;
      bpa_pkg::OP_GB_RD_BUDDY: begin
        mem_re   = 1'b1;
        mem_addr = base_tab[gk_r] + AW'(gi_r ^ IW'(1));
      end
      bpa_pkg::OP_GB_MERGE: begin
        mem_we   = 1'b1;
        mem_addr = base_tab[gk_r] + AW'(gi_r ^ IW'(1));
      end
      bpa_pkg::OP_GB_SET: begin
        mem_we   = 1'b1;
        mem_wbit = 1'b1;
        mem_addr = base_tab[gk_r] + AW'(gi_r);
      end
      default: ;
    endcase
  end

  // Bitmap memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wbit;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  // Control registers: region base and clearing counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_base_r <= '0;
      clr_r         <= '0;
    end else begin
      if (cfg_we) begin
        region_base_r <= cfg_wdata;
      end
      if (op == bpa_pkg::OP_CLR && clr_r != AW'(MEM_DEPTH - 1)) begin
        clr_r <= clr_r + AW'(1);
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    case (op)
      bpa_pkg::OP_LOAD: begin
        cmd_r    <= in_command;
        need_r   <= need_c;
        so_r     <= in_start_order;
        first_r  <= PN_W'(offs >> SHIFT);
        addr_r   <= '0;
        status_r <= bpa_pkg::ST_OK;
      end
      bpa_pkg::OP_SET_ST1: status_r <= bpa_pkg::ST_NO_FREE;
      bpa_pkg::OP_SET_ST2: status_r <= bpa_pkg::ST_BAD_SZ;
      bpa_pkg::OP_SRCH_INIT: begin
        k_r <= KW'(so_r);
        i_r <= '0;
      end
      bpa_pkg::OP_SRCH_NEXT_I: i_r <= i_r + IW'(1);
      bpa_pkg::OP_SRCH_NEXT_K: begin
        k_r <= k_r + KW'(1);
        i_r <= '0;
      end
      bpa_pkg::OP_TAKE: begin
        addr_r  <= region_base_r + (32'(pn_c) << SHIFT);
        next_r  <= pn_c + PN_W'(need_r);
        spare_r <= (MAX_ORDER + 1)'(blk_pages - 32'(need_r));
        j_r     <= '0;
      end
      bpa_pkg::OP_ALLOC_GB: begin
        gk_r   <= j_r;
        gpn_r  <= next_r;
        next_r <= next_r + (PN_W'(1) << j_r);
        j_r    <= j_r + KW'(1);
      end
      bpa_pkg::OP_J_INC: j_r <= j_r + KW'(1);
      bpa_pkg::OP_FREE_INIT: begin
        left_r <= LW'(need_r);
        j_r    <= '0;
      end
      bpa_pkg::OP_FREE_GB: begin
        left_r <= left_dec;
        gk_r   <= j_r;
        gpn_r  <= first_r + PN_W'(left_dec);
        j_r    <= j_r + KW'(1);
      end
      bpa_pkg::OP_TOP_INIT: m_r <= '0;
      bpa_pkg::OP_TOP_GB: begin
        gk_r  <= KW'(MAX_ORDER);
        gpn_r <= first_r + m_r;
        m_r   <= m_r + PN_W'(1 << MAX_ORDER);
      end
      bpa_pkg::OP_TOP_SKIP: m_r <= m_r + PN_W'(1 << MAX_ORDER);
      bpa_pkg::OP_GB_IDX:   gi_r <= IW'(gpn_r >> gk_r);
      bpa_pkg::OP_GB_MERGE: begin
        gi_r <= gi_r >> 1;
        gk_r <= gk_r + KW'(1);
      end
      default: ;
    endcase
  end

  assign out_block_address = addr_r;
  assign out_status        = status_r;

endmodule

FILE: hw/rtl/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// Buddy page allocator controller
// Sequences the clearing pass, the order search, the split of spare pages and
// the buddy merges by issuing at most one datapath micro-operation per cycle.
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  output logic            out_valid,
  input  bpa_pkg::flags_t flags,
  output bpa_pkg::op_t    op
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_SRCH_RD, S_SRCH_CHK, S_ALLOC_BIT,
    S_FREE_BIT, S_FREE_TOP, S_GB_CHK, S_GB_RD, S_GB_EVAL, S_DONE
  } state_t;

  typedef enum logic [1:0] {R_ALLOC, R_FREE, R_TOP} ret_t;

  state_t state_r, state_nxt, ret_state;
  ret_t   ret_r, ret_nxt;
  logic   busy_r, busy_nxt;
  logic   done_r, done_nxt;

  // Where a finished block give-back resumes.
  always_comb begin
    case (ret_r)
      R_ALLOC: ret_state = S_ALLOC_BIT;
      R_FREE:  ret_state = S_FREE_BIT;
      R_TOP:   ret_state = S_FREE_TOP;
      default: ret_state = S_DONE;
    endcase
  end

  // Next-state and micro-operation decode.
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    op        = bpa_pkg::OP_NONE;
    case (state_r)
      S_CLEAR: begin
        op = bpa_pkg::OP_CLR;
        if (flags.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op        = bpa_pkg::OP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!flags.is_free) begin
          if (flags.need_zero) begin
            op        = bpa_pkg::OP_SET_ST2;
            state_nxt = S_DONE;
          end else if (flags.so_over) begin
            op        = bpa_pkg::OP_SET_ST1;
            state_nxt = S_DONE;
          end else begin
            op        = bpa_pkg::OP_SRCH_INIT;
            state_nxt = S_SRCH_RD;
          end
        end else if (flags.need_zero || flags.need_over_total) begin
          op        = bpa_pkg::OP_SET_ST2;
          state_nxt = S_DONE;
        end else begin
          op        = bpa_pkg::OP_FREE_INIT;
          state_nxt = S_FREE_BIT;
        end
      end
      S_SRCH_RD: begin
        if (flags.in_order) begin
          op        = bpa_pkg::OP_SRCH_READ;
          state_nxt = S_SRCH_CHK;
        end else if (!flags.k_top) begin
          op = bpa_pkg::OP_SRCH_NEXT_K;
        end else begin
          op        = bpa_pkg::OP_SET_ST1;
          state_nxt = S_DONE;
        end
      end
      S_SRCH_CHK: begin
        if (!flags.rbit) begin
          op        = bpa_pkg::OP_SRCH_NEXT_I;
          state_nxt = S_SRCH_RD;
        end else if (flags.need_gt_blk) begin
          op        = bpa_pkg::OP_SET_ST2;
          state_nxt = S_DONE;
        end else begin
          op        = bpa_pkg::OP_TAKE;
          state_nxt = S_ALLOC_BIT;
        end
      end
      S_ALLOC_BIT: begin
        if (!flags.j_lt_k) begin
          state_nxt = S_DONE;
        end else if (flags.spare_bit) begin
          op        = bpa_pkg::OP_ALLOC_GB;
          ret_nxt   = R_ALLOC;
          state_nxt = S_GB_CHK;
        end else begin
          op = bpa_pkg::OP_J_INC;
        end
      end
      S_FREE_BIT: begin
        if (!flags.j_lt_max) begin
          op        = bpa_pkg::OP_TOP_INIT;
          state_nxt = S_FREE_TOP;
        end else if (flags.left_bit) begin
          op        = bpa_pkg::OP_FREE_GB;
          ret_nxt   = R_FREE;
          state_nxt = S_GB_CHK;
        end else begin
          op = bpa_pkg::OP_J_INC;
        end
      end
      S_FREE_TOP: begin
        if (!flags.m_lt_left) begin
          state_nxt = S_DONE;
        end else if (flags.top_in_range) begin
          op        = bpa_pkg::OP_TOP_GB;
          ret_nxt   = R_TOP;
          state_nxt = S_GB_CHK;
        end else begin
          op = bpa_pkg::OP_TOP_SKIP;
        end
      end
      // Give back one block: drop it when misaligned or outside the region.
      S_GB_CHK: begin
        if (flags.gb_bad) begin
          state_nxt = ret_state;
        end else begin
          op        = bpa_pkg::OP_GB_IDX;
          state_nxt = S_GB_RD;
        end
      end
      S_GB_RD: begin
        if (flags.gb_buddy) begin
          op        = bpa_pkg::OP_GB_RD_BUDDY;
          state_nxt = S_GB_EVAL;
        end else begin
          op        = bpa_pkg::OP_GB_SET;
          state_nxt = ret_state;
        end
      end
      S_GB_EVAL: begin
        if (flags.rbit) begin
          op        = bpa_pkg::OP_GB_MERGE;
          state_nxt = S_GB_RD;
        end else begin
          op        = bpa_pkg::OP_GB_SET;
          state_nxt = ret_state;
        end
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    busy_nxt = (state_nxt != S_IDLE);
    done_nxt = (state_nxt == S_DONE);
  end

  // State and registered handshake outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ret_r   <= R_ALLOC;
      busy_r  <= 1'b1;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = done_r;

endmodule

FILE: hw/rtl/buddy_page_allocator.sv
// ----------------------------------------------------------------------------
// Buddy page allocator
// Allocates and frees page blocks over a fixed region using per-order bitmaps.
// ----------------------------------------------------------------------------
// A request is taken when start is high while busy is low; its one result
// appears on the out_ ports for a single cycle with out_valid, and the
// receiver cannot hold it off. After reset the block initialises its bitmap
// memory, marking only the top-order blocks free, and keeps busy high. The
// time a request takes grows with the bitmap bits visited in the order
// search, the orders stepped past, the spare or freed bit positions examined,
// the blocks given back and the buddy merges, since the single-port bitmap
// memory reads or writes one bit per access.
module buddy_page_allocator #(
  parameter int PAGE_BYTES  = 4096,
  parameter int MAX_ORDER   = 8,
  parameter int TOTAL_PAGES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [22:0] in_size_bytes,
  input  logic [3:0]  in_start_order,
  input  logic [31:0] in_free_address,
  output logic        out_valid,
  output logic [31:0] out_block_address,
  output logic [1:0]  out_status
);

  bpa_pkg::op_t    op;
  bpa_pkg::flags_t flags;

  // Sequencer.
  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .flags     (flags),
    .op        (op)
  );

  // Bitmap memory and arithmetic.
  bpa_datapath #(
    .PAGE_BYTES  (PAGE_BYTES),
    .MAX_ORDER   (MAX_ORDER),
    .TOTAL_PAGES (TOTAL_PAGES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .op                (op),
    .flags             (flags),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_command        (in_command),
    .in_size_bytes     (in_size_bytes),
    .in_start_order    (in_start_order),
    .in_free_address   (in_free_address),
    .out_block_address (out_block_address),
    .out_status        (out_status)
  );

endmodule

FILE: hw/rtl/bpa_checker.sv
// ----------------------------------------------------------------------------
// Buddy page allocator port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module bpa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_block_address,
  input logic [1:0]  out_status
);

  // A transfer request puts the block to work on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted request did not raise busy");

  // A result strobe lasts exactly one cycle.
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  // A result only appears while the request is still owned by the block.
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result shown while idle");

  // Failures carry a zero address.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != bpa_pkg::ST_OK |-> out_block_address == 32'd0)
    else $error("failed request returned an address");

  // Status code three is never produced.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3) else $error("undefined status code");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_block_address (out_block_address),
  .out_status        (out_status)
);
